/* rtl/assert_macros.svh */
// concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)

`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

/* rtl/rc5_pkg.sv */
package rc5_pkg;

  localparam int unsigned CapW  = 16;
  localparam int unsigned CntW  = 6;
  localparam int unsigned WordW = 13;
  localparam int unsigned BitsW = 4;
  localparam int unsigned AddrW = 8;
  localparam int unsigned KeyW  = 6;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [BitsW-1:0] LastBit = 4'd12;
  localparam logic [AddrW-1:0] AddrAck = 8'hFF;

  typedef enum logic {
    CMD_EDGE = 1'b0,
    CMD_ACK  = 1'b1
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SHORTEST_PULSE = 2'd0,
    REG_LONGEST_HALF   = 2'd1,
    REG_MAX_BIT        = 2'd2,
    REG_UNUSED         = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [CapW-1:0] shortest_pulse;
    logic [CapW-1:0] longest_half;
    logic [CapW-1:0] max_bit;
  } cfg_t;

  typedef struct packed {
    logic [CapW-1:0]  last_capture;
    logic             edge_polarity;
    logic [CntW-1:0]  half_bit_count;
    logic [WordW-1:0] shift_word;
    logic [BitsW-1:0] bits_received;
    logic             pending_flag;
    logic [AddrW-1:0] held_address;
    logic [KeyW-1:0]  held_key;
    logic             held_toggle;
  } frame_state_t;

  typedef struct packed {
    logic             toggle;
    logic [KeyW-1:0]  key_code;
    logic [AddrW-1:0] device_address;
    logic             frame_done;
    logic             key_pending;
  } result_t;

endpackage

/* rtl/rc5_step.sv */
module rc5_step import rc5_pkg::*; (
  input  cfg_t            cfg_i,
  input  frame_state_t    state_i,
  input  cmd_e            cmd_i,
  input  logic [CapW-1:0] capture_time_i,
  output frame_state_t    state_o,
  output result_t         result_o
);

  logic [CapW-1:0]  width;
  logic [CntW-1:0]  cnt;
  logic [CntW-1:0]  cnt_adv;
  logic [BitsW-1:0] bits_inc;
  logic [WordW-1:0] word_sh;
  logic             pol;
  logic             done;
  frame_state_t     s;

  always_comb begin
    s        = state_i;
    done     = 1'b0;
    width    = capture_time_i - state_i.last_capture;
    pol      = ~state_i.edge_polarity;
    cnt      = (width > cfg_i.max_bit) ? '0 : state_i.half_bit_count;
    cnt_adv  = (width > cfg_i.longest_half) ? cnt + 1'b1 : cnt;
    bits_inc = state_i.bits_received + 1'b1;
    word_sh  = {state_i.shift_word[WordW-2:0], pol};

    unique case (cmd_i)
      CMD_ACK: begin
        s.pending_flag = 1'b0;
        s.held_address = AddrAck;
      end
      CMD_EDGE: begin
        s.last_capture  = capture_time_i;
        s.edge_polarity = pol;
        if (cnt == '0) begin
          s.shift_word     = '0;
          s.bits_received  = '0;
          s.edge_polarity  = 1'b1;
          s.half_bit_count = CntW'(1);
        end else if (width < cfg_i.shortest_pulse) begin
          s.half_bit_count = '0;
          s.edge_polarity  = 1'b0;
        end else begin
          s.half_bit_count = cnt_adv + 1'b1;
          if (cnt_adv > CntW'(1) && !cnt_adv[0]) begin
            s.shift_word    = word_sh;
            s.bits_received = bits_inc;
            if (bits_inc > LastBit) begin
              if (!state_i.pending_flag) begin
                s.held_key     = word_sh[KeyW-1:0];
                s.held_address = AddrW'(word_sh[10:6]);
                s.held_toggle  = word_sh[11];
              end
              s.pending_flag   = 1'b1;
              done             = 1'b1;
              s.half_bit_count = '0;
              s.edge_polarity  = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign state_o                 = s;
  assign result_o.key_pending    = s.pending_flag;
  assign result_o.frame_done     = done;
  assign result_o.device_address = s.held_address;
  assign result_o.key_code       = s.held_key;
  assign result_o.toggle         = s.held_toggle;

endmodule

/* rtl/rc5_ir_frame_decoder.sv */
// channel      | direction | tdata (low bit first)                         | tuser
// s_axis       | in        | capture_time[15:0]                            | command
// m_axis       | out       | key_pending, frame_done, device_address[7:0], | none
//              |           | key_code[5:0], toggle, zero fill to 24 bits   |
// cfg          | in        | cfg_we_i, cfg_idx_i, cfg_data_i               | none
//
// one item per cycle while m_axis_tready is high; each item passes from the input register into the result register
// the edge state updates as the item moves from the input register to the result register
// input register refills in the cycle the result register is taken, so no bubbles under flow
// reset clears control state and the decode state, thresholds return to 640/1140/2000
`include "assert_macros.svh"

module rc5_ir_frame_decoder import rc5_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CapW-1:0]    cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,   // capture_time
  input  logic [0:0]         s_axis_tuser,   // command
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [23:0]        m_axis_tdata    // key_pending, frame_done, device_address,
                                             // key_code, toggle, zeros
);

  cfg_t            cfg_q;
  frame_state_t    state_q, state_d;
  result_t         res_q, res_d;
  logic            in_valid_q, out_valid_q;
  cmd_e            cmd_q;
  logic [CapW-1:0] cap_q;
  logic            advance;
  logic            in_fire;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.shortest_pulse <= 16'd640;
      cfg_q.longest_half   <= 16'd1140;
      cfg_q.max_bit        <= 16'd2000;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_SHORTEST_PULSE: cfg_q.shortest_pulse <= cfg_data_i;
        REG_LONGEST_HALF:   cfg_q.longest_half   <= cfg_data_i;
        REG_MAX_BIT:        cfg_q.max_bit        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= cmd_e'(s_axis_tuser[0]);
      cap_q <= s_axis_tdata;
    end
  end

  rc5_step u_step (
    .cfg_i          (cfg_q),
    .state_i        (state_q),
    .cmd_i          (cmd_q),
    .capture_time_i (cap_q),
    .state_o        (state_d),
    .result_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, res_q};

  `ASSERT_CLK(a_done_sets_pending, clk_i, rst_ni,
    (out_valid_q && res_q.frame_done) |-> res_q.key_pending)
  `ASSERT_CLK(a_pending_from_edge, clk_i, rst_ni,
    $rose(state_q.pending_flag) |-> $past(advance && cmd_q == CMD_EDGE))
  `ASSERT_CLK(a_result_from_input, clk_i, rst_ni,
    (out_valid_q && !$past(out_valid_q)) |-> $past(in_valid_q))
  `ASSERT_NEVER(a_bit_count_range, clk_i, rst_ni,
    state_q.bits_received > (LastBit + 4'd1))

endmodule
